/* rtl/ptc_pkg.sv */
package ptc_pkg;

  localparam int VERTS_DEF       = 1024;
  localparam int NEIGHBORS_DEF   = 16384;
  localparam int VERTEX_BITS_DEF = 32;

  // row-start entries keep 15 bits whatever the store depth
  localparam int ROW_W = 15;

  localparam logic [14:0] COUNT_MAX = 15'h7fff;
  localparam logic [47:0] SUM_MAX   = 48'hffff_ffff_ffff;
  localparam logic [31:0] ERR_MAX   = 32'hffff_ffff;

  localparam logic [2:0] OP_ROW_ONE = 3'd0;
  localparam logic [2:0] OP_NB_ONE  = 3'd1;
  localparam logic [2:0] OP_ROW_TWO = 3'd2;
  localparam logic [2:0] OP_NB_TWO  = 3'd3;
  localparam logic [2:0] OP_EDGE    = 3'd4;

  localparam logic [1:0] CFG_ONE_FIRST = 2'd0;
  localparam logic [1:0] CFG_ONE_LAST  = 2'd1;
  localparam logic [1:0] CFG_TWO_FIRST = 2'd2;
  localparam logic [1:0] CFG_TWO_LAST  = 2'd3;

  localparam logic [31:0] ONE_FIRST_RST = 32'd0;
  localparam logic [31:0] ONE_LAST_RST  = 32'd1023;
  localparam logic [31:0] TWO_FIRST_RST = 32'd0;
  localparam logic [31:0] TWO_LAST_RST  = 32'd1023;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [13:0] slot;
    logic [31:0] load_value;
    logic [31:0] edge_from;
    logic [31:0] edge_to;
  } in_word_t;

  typedef struct packed {
    logic [14:0] common_neighbors;
    logic        out_of_range;
    logic [47:0] total_triangles;
    logic [31:0] total_out_of_range;
  } out_word_t;

  // write request into one partition's tables
  typedef struct packed {
    logic        row_en;
    logic        nb_en;
    logic [13:0] slot;
    logic [31:0] value;
  } ptc_load_t;

endpackage

/* rtl/ptc_part.sv */
module ptc_part #(
  parameter int VERTS       = ptc_pkg::VERTS_DEF,
  parameter int NEIGHBORS   = ptc_pkg::NEIGHBORS_DEF,
  parameter int VERTEX_BITS = ptc_pkg::VERTEX_BITS_DEF,
  localparam int AW = $clog2(VERTS + 1),
  localparam int NW = $clog2(NEIGHBORS)
) (
  input  logic                        clk,
  input  ptc_pkg::ptc_load_t          load,
  input  logic [AW-1:0]               row_addr,
  output logic [ptc_pkg::ROW_W-1:0]   row_data,
  input  logic [NW-1:0]               nb_addr,
  output logic [VERTEX_BITS-1:0]      nb_data
);
  import ptc_pkg::*;

  logic [ROW_W-1:0]       row_mem [VERTS+1];
  logic [VERTEX_BITS-1:0] nb_mem  [NEIGHBORS];
  logic [ROW_W-1:0]       row_data_r;
  logic [VERTEX_BITS-1:0] nb_data_r;

  logic [31:0] slot_ext;
  logic [63:0] value_ext;

  assign slot_ext  = 32'(load.slot);
  assign value_ext = 64'(load.value);

  always_ff @(posedge clk) begin
    if (load.row_en && slot_ext <= 32'(VERTS)) begin
      row_mem[slot_ext[AW-1:0]] <= load.value[ROW_W-1:0];
    end
    row_data_r <= row_mem[row_addr];
  end

  always_ff @(posedge clk) begin
    if (load.nb_en && slot_ext < 32'(NEIGHBORS)) begin
      nb_mem[slot_ext[NW-1:0]] <= value_ext[VERTEX_BITS-1:0];
    end
    nb_data_r <= nb_mem[nb_addr];
  end

  assign row_data = row_data_r;
  assign nb_data  = nb_data_r;

endmodule

/* rtl/ptc_seq.sv */
module ptc_seq #(
  parameter int VERTS       = ptc_pkg::VERTS_DEF,
  parameter int NEIGHBORS   = ptc_pkg::NEIGHBORS_DEF,
  parameter int VERTEX_BITS = ptc_pkg::VERTEX_BITS_DEF,
  localparam int AW = $clog2(VERTS + 1),
  localparam int NW = $clog2(NEIGHBORS),
  localparam int PW = $clog2(NEIGHBORS + 1)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  ptc_pkg::in_word_t           in_word,
  output logic                        out_valid,
  input  logic                        out_stall,
  output ptc_pkg::out_word_t          out_word,
  input  logic                        cfg_wr_en,
  input  logic [1:0]                  cfg_index,
  input  logic [31:0]                 cfg_data,
  output ptc_pkg::ptc_load_t          load_one,
  output ptc_pkg::ptc_load_t          load_two,
  output logic [AW-1:0]               row_addr_one,
  output logic [AW-1:0]               row_addr_two,
  input  logic [ptc_pkg::ROW_W-1:0]   row_data_one,
  input  logic [ptc_pkg::ROW_W-1:0]   row_data_two,
  output logic [NW-1:0]               nb_addr_one,
  output logic [NW-1:0]               nb_addr_two,
  input  logic [VERTEX_BITS-1:0]      nb_data_one,
  input  logic [VERTEX_BITS-1:0]      nb_data_two
);
  import ptc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_RANGE, S_LOCAL, S_ROW0, S_ROW1, S_MERGE, S_DONE
  } state_t;

  state_t      state_r, state_nxt;
  logic [31:0] one_first_r, one_last_r, two_first_r, two_last_r;
  logic [31:0] from_r, from_nxt, to_r, to_nxt;
  logic [31:0] a_r, a_nxt, b_r, b_nxt;
  logic        flag_r, flag_nxt;
  logic [PW-1:0] u_r, u_nxt, v_r, v_nxt, hia_r, hia_nxt, hib_r, hib_nxt;
  logic [PW-1:0] found_r, found_nxt;
  logic [47:0] tri_r, tri_nxt;
  logic [31:0] err_r, err_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_word_t   out_word_r, out_word_nxt;

  logic        accept;
  logic [48:0] tri_sum;
  logic [14:0] count_sat;

  function automatic logic [PW-1:0] clamp_row(input logic [ROW_W-1:0] row);
    if (32'(row) > 32'(NEIGHBORS)) begin
      return PW'(NEIGHBORS);
    end
    return PW'(row);
  endfunction

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    load_one        = '0;
    load_two        = '0;
    load_one.slot   = in_word.slot;
    load_one.value  = in_word.load_value;
    load_two.slot   = in_word.slot;
    load_two.value  = in_word.load_value;
    load_one.row_en = accept && in_word.opcode == OP_ROW_ONE;
    load_one.nb_en  = accept && in_word.opcode == OP_NB_ONE;
    load_two.row_en = accept && in_word.opcode == OP_ROW_TWO;
    load_two.nb_en  = accept && in_word.opcode == OP_NB_TWO;
  end

  // second row read fetches the end of the row
  assign row_addr_one = (state_r == S_ROW0) ? a_r[AW-1:0] + AW'(1) : a_r[AW-1:0];
  assign row_addr_two = (state_r == S_ROW0) ? b_r[AW-1:0] + AW'(1) : b_r[AW-1:0];

  // store reads follow the next pointers so data lines up with u_r / v_r
  assign nb_addr_one = u_nxt[NW-1:0];
  assign nb_addr_two = v_nxt[NW-1:0];

  assign tri_sum   = {1'b0, tri_r} + 49'(found_r);
  assign count_sat = (32'(found_r) > 32'(COUNT_MAX)) ? COUNT_MAX : 15'(found_r);

  always_comb begin
    state_nxt     = state_r;
    from_nxt      = from_r;
    to_nxt        = to_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    flag_nxt      = flag_r;
    u_nxt         = u_r;
    v_nxt         = v_r;
    hia_nxt       = hia_r;
    hib_nxt       = hib_r;
    found_nxt     = found_r;
    tri_nxt       = tri_r;
    err_nxt       = err_r;
    out_word_nxt  = out_word_r;
    out_valid_nxt = out_valid_r && out_stall;

    unique case (state_r)
      S_IDLE: begin
        if (accept && in_word.opcode == OP_EDGE) begin
          from_nxt  = in_word.edge_from;
          to_nxt    = in_word.edge_to;
          flag_nxt  = 1'b0;
          found_nxt = '0;
          state_nxt = S_RANGE;
        end
      end
      S_RANGE: begin
        if (from_r < one_first_r || from_r > one_last_r ||
            to_r < two_first_r || to_r > two_last_r) begin
          flag_nxt  = 1'b1;
          state_nxt = S_DONE;
        end else begin
          a_nxt     = from_r - one_first_r;
          b_nxt     = to_r - two_first_r;
          state_nxt = S_LOCAL;
        end
      end
      S_LOCAL: begin
        if (a_r >= 32'(VERTS) || b_r >= 32'(VERTS)) begin
          flag_nxt  = 1'b1;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_ROW0;
        end
      end
      S_ROW0: begin
        u_nxt     = clamp_row(row_data_one);
        v_nxt     = clamp_row(row_data_two);
        state_nxt = S_ROW1;
      end
      S_ROW1: begin
        hia_nxt   = clamp_row(row_data_one);
        hib_nxt   = clamp_row(row_data_two);
        state_nxt = S_MERGE;
      end
      S_MERGE: begin
        if (u_r < hia_r && v_r < hib_r) begin
          priority if (nb_data_one < nb_data_two) begin
            u_nxt = u_r + PW'(1);
          end else if (nb_data_one > nb_data_two) begin
            v_nxt = v_r + PW'(1);
          end else begin
            u_nxt     = u_r + PW'(1);
            v_nxt     = v_r + PW'(1);
            found_nxt = found_r + PW'(1);
          end
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          if (flag_r) begin
            err_nxt = (err_r == ERR_MAX) ? err_r : err_r + 32'd1;
            tri_nxt = tri_r;
          end else begin
            tri_nxt = (tri_sum > 49'(SUM_MAX)) ? SUM_MAX : tri_sum[47:0];
          end
          out_word_nxt.common_neighbors   = flag_r ? 15'd0 : count_sat;
          out_word_nxt.out_of_range       = flag_r;
          out_word_nxt.total_triangles    = tri_nxt;
          out_word_nxt.total_out_of_range = err_nxt;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      tri_r       <= '0;
      err_r       <= '0;
      one_first_r <= ONE_FIRST_RST;
      one_last_r  <= ONE_LAST_RST;
      two_first_r <= TWO_FIRST_RST;
      two_last_r  <= TWO_LAST_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      tri_r       <= tri_nxt;
      err_r       <= err_nxt;
      if (cfg_wr_en) begin
        unique case (cfg_index)
          CFG_ONE_FIRST: one_first_r <= cfg_data;
          CFG_ONE_LAST:  one_last_r  <= cfg_data;
          CFG_TWO_FIRST: two_first_r <= cfg_data;
          CFG_TWO_LAST:  two_last_r  <= cfg_data;
          default: ;
        endcase
      end
    end
    from_r     <= from_nxt;
    to_r       <= to_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    flag_r     <= flag_nxt;
    u_r        <= u_nxt;
    v_r        <= v_nxt;
    hia_r      <= hia_nxt;
    hib_r      <= hib_nxt;
    found_r    <= found_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

/* rtl/partitioned_triangle_count.sv */
// channel  | direction | handshake           | word
// ---------+-----------+---------------------+--------------------------------
// in_      | into      | in_valid / in_stall | in_word (opcode, slot, load,
//          |           |                     |   edge_from, edge_to)
// out_     | out of    | out_valid/out_stall | out_word (count, flag, totals)
// cfg_     | into      | cfg_wr_en           | cfg_index, cfg_data
//
// A load word is written to its table at the accept edge. An edge runs S_RANGE,
// S_LOCAL, S_ROW0, S_ROW1, S_MERGE, S_DONE; a range or local index fail skips
// to S_DONE. In S_MERGE the one shared compare unit walks both sorted lists,
// one neighbor pair per cycle. rst_n is synchronous; it clears control and
// totals, resets range registers, the tables are not cleared. A finished result
// sits in the output register while the next word is taken; only the final
// result write waits on out_stall.
module partitioned_triangle_count #(
  parameter int VERTS       = ptc_pkg::VERTS_DEF,
  parameter int NEIGHBORS   = ptc_pkg::NEIGHBORS_DEF,
  parameter int VERTEX_BITS = ptc_pkg::VERTEX_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ptc_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output ptc_pkg::out_word_t out_word,
  input  logic               cfg_wr_en,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import ptc_pkg::*;

  localparam int AW = $clog2(VERTS + 1);
  localparam int NW = $clog2(NEIGHBORS);

  ptc_load_t              load_one, load_two;
  logic [AW-1:0]          row_addr_one, row_addr_two;
  logic [ROW_W-1:0]       row_data_one, row_data_two;
  logic [NW-1:0]          nb_addr_one, nb_addr_two;
  logic [VERTEX_BITS-1:0] nb_data_one, nb_data_two;

  ptc_part #(
    .VERTS(VERTS), .NEIGHBORS(NEIGHBORS), .VERTEX_BITS(VERTEX_BITS)
  ) u_part_one (
    .clk      (clk),
    .load     (load_one),
    .row_addr (row_addr_one),
    .row_data (row_data_one),
    .nb_addr  (nb_addr_one),
    .nb_data  (nb_data_one)
  );

  ptc_part #(
    .VERTS(VERTS), .NEIGHBORS(NEIGHBORS), .VERTEX_BITS(VERTEX_BITS)
  ) u_part_two (
    .clk      (clk),
    .load     (load_two),
    .row_addr (row_addr_two),
    .row_data (row_data_two),
    .nb_addr  (nb_addr_two),
    .nb_data  (nb_data_two)
  );

  ptc_seq #(
    .VERTS(VERTS), .NEIGHBORS(NEIGHBORS), .VERTEX_BITS(VERTEX_BITS)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_word      (in_word),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_word     (out_word),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .load_one     (load_one),
    .load_two     (load_two),
    .row_addr_one (row_addr_one),
    .row_addr_two (row_addr_two),
    .row_data_one (row_data_one),
    .row_data_two (row_data_two),
    .nb_addr_one  (nb_addr_one),
    .nb_addr_two  (nb_addr_two),
    .nb_data_one  (nb_data_one),
    .nb_data_two  (nb_data_two)
  );

endmodule

/* rtl/ptc_check.sv */
module ptc_check (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input ptc_pkg::in_word_t  in_word,
  input logic               out_valid,
  input logic               out_stall,
  input ptc_pkg::out_word_t out_word
);
  import ptc_pkg::*;

  // a held result word must not move
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("result word changed while stalled");

  // an accepted edge occupies the sequencer for at least the next cycle
  a_edge_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_word.opcode == OP_EDGE |=> in_stall)
    else $error("edge word accepted without going busy");

  a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.out_of_range |-> out_word.common_neighbors == 15'd0)
    else $error("flagged edge reports common neighbours");

  a_flag_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.out_of_range |-> out_word.total_out_of_range != 32'd0)
    else $error("flagged edge not counted in error total");

  a_tri_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_word.out_of_range |->
      out_word.total_triangles >= 48'(out_word.common_neighbors))
    else $error("triangle total below this edge's count");

endmodule

bind partitioned_triangle_count ptc_check u_ptc_check (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_word   (in_word),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);

/* tb/sv/tri_check_pkg.sv */
package tri_check_pkg;
  import ptc_pkg::*;

  localparam int VERTS     = VERTS_DEF;
  localparam int NEIGHBORS = NEIGHBORS_DEF;

  class tri_count_board;
    logic [31:0] part_first [2];
    logic [31:0] part_last  [2];
    logic [14:0] row_start  [2][VERTS+1];
    bit          row_written[2][VERTS+1];
    logic [31:0] nbr_id     [2][NEIGHBORS];
    bit          nbr_written[2][NEIGHBORS];
    logic [47:0] triangle_total;
    logic [31:0] flagged_total;
    out_word_t   due_words[$];
    int unsigned mismatches;

    function new();
      part_first[0]  = ONE_FIRST_RST;
      part_last[0]   = ONE_LAST_RST;
      part_first[1]  = TWO_FIRST_RST;
      part_last[1]   = TWO_LAST_RST;
      triangle_total = '0;
      flagged_total  = '0;
      mismatches     = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] data);
      case (idx)
        CFG_ONE_FIRST: part_first[0] = data;
        CFG_ONE_LAST:  part_last[0]  = data;
        CFG_TWO_FIRST: part_first[1] = data;
        CFG_TWO_LAST:  part_last[1]  = data;
      endcase
    endfunction

    // row starts past the store end point at the end
    function int clip(logic [14:0] r);
      return (int'(r) > NEIGHBORS) ? NEIGHBORS : int'(r);
    endfunction

    // 1 when the edge is flagged; otherwise the local indices
    function bit locate(logic [31:0] from, logic [31:0] to, output int a, output int b);
      logic [31:0] da, db;
      a = 0;
      b = 0;
      if (from < part_first[0] || from > part_last[0] ||
          to < part_first[1] || to > part_last[1])
        return 1'b1;
      da = from - part_first[0];
      db = to - part_first[1];
      if (da >= VERTS || db >= VERTS)
        return 1'b1;
      a = int'(da);
      b = int'(db);
      return 1'b0;
    endfunction

    function bit row_ready(int p, int l);
      int lo, hi;
      if (!row_written[p][l] || !row_written[p][l+1])
        return 1'b0;
      lo = clip(row_start[p][l]);
      hi = clip(row_start[p][l+1]);
      for (int i = lo; i < hi; i++)
        if (!nbr_written[p][i])
          return 1'b0;
      return 1'b1;
    endfunction

    // an edge is safe to send when it touches no table entry left unwritten
    function bit edge_safe(logic [31:0] from, logic [31:0] to);
      int a, b;
      if (locate(from, to, a, b))
        return 1'b1;
      return row_ready(0, a) && row_ready(1, b);
    endfunction

    function logic [31:0] flagged_source();
      if (part_first[0] > part_last[0])
        return part_first[0];
      else if (part_last[0] - part_first[0] >= VERTS)
        return part_first[0] + VERTS;
      else if (part_first[0] != '0)
        return part_first[0] - 1;
      else
        return part_last[0] + 1;
    endfunction

    function int merge_count(int a, int b);
      int u, v, u_end, v_end, hits;
      u     = clip(row_start[0][a]);
      u_end = clip(row_start[0][a+1]);
      v     = clip(row_start[1][b]);
      v_end = clip(row_start[1][b+1]);
      hits  = 0;
      while (u < u_end && v < v_end) begin
        if (nbr_id[0][u] < nbr_id[1][v]) begin
          u++;
        end else if (nbr_id[0][u] > nbr_id[1][v]) begin
          v++;
        end else begin
          u++;
          v++;
          hits++;
        end
      end
      return hits;
    endfunction

    function void note_word(in_word_t w);
      int a, b, hits, p;
      bit flag;
      out_word_t want;
      p = (w.opcode == OP_ROW_TWO || w.opcode == OP_NB_TWO) ? 1 : 0;
      case (w.opcode)
        OP_ROW_ONE, OP_ROW_TWO: begin
          if (w.slot <= VERTS) begin
            row_start[p][w.slot]   = w.load_value[14:0];
            row_written[p][w.slot] = 1'b1;
          end
        end
        OP_NB_ONE, OP_NB_TWO: begin
          if (w.slot < NEIGHBORS) begin
            nbr_id[p][w.slot]      = w.load_value;
            nbr_written[p][w.slot] = 1'b1;
          end
        end
        OP_EDGE: begin
          hits = 0;
          flag = locate(w.edge_from, w.edge_to, a, b);
          if (!flag)
            hits = merge_count(a, b);
          if (flag) begin
            if (flagged_total != ERR_MAX)
              flagged_total++;
          end else if (48'(hits) > SUM_MAX - triangle_total) begin
            triangle_total = SUM_MAX;
          end else begin
            triangle_total += 48'(hits);
          end
          want.common_neighbors   = (hits > int'(COUNT_MAX)) ? COUNT_MAX : 15'(hits);
          want.out_of_range       = flag;
          want.total_triangles    = triangle_total;
          want.total_out_of_range = flagged_total;
          due_words.push_back(want);
        end
        default: ;
      endcase
    endfunction

    function void check_word(out_word_t got);
      out_word_t want;
      if (due_words.size() == 0) begin
        $error("result word with nothing outstanding: %h", got);
        mismatches++;
        return;
      end
      want = due_words.pop_front();
      if (got.common_neighbors !== want.common_neighbors) begin
        $error("common_neighbors: expected %0d, got %0d",
               want.common_neighbors, got.common_neighbors);
        mismatches++;
      end
      if (got.out_of_range !== want.out_of_range) begin
        $error("out_of_range: expected %0d, got %0d", want.out_of_range, got.out_of_range);
        mismatches++;
      end
      if (got.total_triangles !== want.total_triangles) begin
        $error("total_triangles: expected %0d, got %0d",
               want.total_triangles, got.total_triangles);
        mismatches++;
      end
      if (got.total_out_of_range !== want.total_out_of_range) begin
        $error("total_out_of_range: expected %0d, got %0d",
               want.total_out_of_range, got.total_out_of_range);
        mismatches++;
      end
    endfunction
  endclass

endpackage

/* tb/sv/tb_partitioned_triangle_count.sv */
module tb_partitioned_triangle_count;
  import ptc_pkg::*;
  import tri_check_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_word_t    in_word;
  logic        out_valid;
  logic        out_stall;
  out_word_t   out_word;
  logic        cfg_wr_en;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  tri_count_board board;
  int unsigned    in_gap_pct  = 38;
  int unsigned    out_gap_pct = 38;
  int unsigned    results_seen = 0;
  int unsigned    words_sent = 0;
  bit             held_off = 1'b0;
  int             win_base[2];
  int             win_count[2];

  partitioned_triangle_count dut (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #3_200_000;
    $display("Verification failed");
    $finish;
  end

  // receiver: random stalls, plus one long hold-off so the block backs up
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!held_off && results_seen >= 30) begin
        held_off = 1'b1;
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
      end
      out_stall <= ($urandom_range(0, 99) < out_gap_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      board.check_word(out_word);
      results_seen++;
    end
  end

  // called just after a rising edge; returns at the edge that takes the word
  task automatic send_word(input in_word_t w);
    while ($urandom_range(0, 99) < in_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_word(w);
    if (w.opcode <= OP_EDGE)
      words_sent++;
  endtask

  task automatic send_load(input logic [2:0] op, input logic [13:0] slot,
                           input logic [31:0] value);
    in_word_t w;
    w.opcode     = op;
    w.slot       = slot;
    w.load_value = value;
    w.edge_from  = $urandom();
    w.edge_to    = $urandom();
    send_word(w);
  endtask

  // upper bits of a row-start word are dropped by the block
  task automatic send_row(input int p, input int slot, input int off);
    send_load(p ? OP_ROW_TWO : OP_ROW_ONE, 14'(slot),
              ($urandom() & 32'hFFFF_8000) | 32'(off));
  endtask

  task automatic send_edge(input logic [31:0] from, input logic [31:0] to);
    in_word_t w;
    if (!board.edge_safe(from, to))
      from = board.flagged_source();
    w.opcode     = OP_EDGE;
    w.slot       = 14'($urandom());
    w.load_value = $urandom();
    w.edge_from  = from;
    w.edge_to    = to;
    send_word(w);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.due_words.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    board.set_reg(idx, data);
  endtask

  task automatic configure(input logic [31:0] one_first, input logic [31:0] one_last,
                           input logic [31:0] two_first, input logic [31:0] two_last);
    write_reg(CFG_ONE_FIRST, one_first);
    write_reg(CFG_ONE_LAST, one_last);
    write_reg(CFG_TWO_FIRST, two_first);
    write_reg(CFG_TWO_LAST, two_last);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] range_top(input logic [31:0] first);
    logic [31:0] span;
    span = $urandom_range(0, 1500);
    return (first > 32'hFFFF_FFFF - span) ? 32'hFFFF_FFFF : first + span;
  endfunction

  task automatic run_directed();
    // vertex 0 of partition one and vertex VERTS-1 of two share ids 5 and all-ones
    send_load(OP_ROW_ONE, 0, 0);
    send_load(OP_ROW_ONE, 1, 32'h0001_8003);
    send_load(OP_NB_ONE, 0, 5);
    send_load(OP_NB_ONE, 1, 9);
    send_load(OP_NB_ONE, 2, 32'hFFFF_FFFF);
    send_load(OP_ROW_TWO, 14'(VERTS - 1), NEIGHBORS - 3);
    send_load(OP_ROW_TWO, 14'(VERTS), 32'hFFFF_4000);
    send_load(OP_NB_TWO, 14'(NEIGHBORS - 3), 5);
    send_load(OP_NB_TWO, 14'(NEIGHBORS - 2), 7);
    send_load(OP_NB_TWO, 14'(NEIGHBORS - 1), 32'hFFFF_FFFF);
    // both ends of vertex 2 lie past the store: empty row
    send_load(OP_ROW_ONE, 2, 32'hFFFF_FFFF);
    send_load(OP_ROW_ONE, 3, 32'h0000_7FFF);
    // vertex 0 of partition two ends below its start
    send_load(OP_ROW_TWO, 0, 10);
    send_load(OP_ROW_TWO, 1, 4);
    // slots past the row table are dropped
    send_load(OP_ROW_ONE, 14'(VERTS + 1), 0);
    send_load(OP_ROW_TWO, 14'h3FFF, 0);
    for (int k = 1; k <= 3; k++)
      send_load(OP_EDGE + 3'(k), 14'($urandom()), $urandom());
    send_edge(0, VERTS - 1);
    send_edge(2, VERTS - 1);
    send_edge(0, 0);
    send_edge(2, 0);
    send_edge(VERTS, 5);
    send_edge(0, 32'hFFFF_FFFF);
  endtask

  // lay down a few consecutive rows per partition over one id alphabet
  task automatic build_graph();
    int nv, maxlen, nbase, off, len;
    bit scramble;
    logic [31:0] id_base, id;
    id_base = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FF00 - $urandom_range(0, 255)
                                          : $urandom_range(0, 32'hFFFF_F000);
    for (int p = 0; p < 2; p++) begin
      nv           = $urandom_range(1, 6);
      maxlen       = ($urandom_range(0, 9) == 0) ? 40 : 8;
      win_base[p]  = $urandom_range(0, VERTS - nv);
      win_count[p] = nv;
      nbase        = $urandom_range(0, NEIGHBORS - nv * maxlen);
      off          = nbase;
      send_row(p, win_base[p], off);
      for (int v = 0; v < nv; v++) begin
        len      = $urandom_range(0, maxlen);
        scramble = ($urandom_range(0, 14) == 0);
        id       = id_base + $urandom_range(0, 3);
        for (int k = 0; k < len; k++) begin
          if (scramble)
            id = id_base + $urandom_range(0, 30);
          send_load(p ? OP_NB_TWO : OP_NB_ONE, 14'(off + k), id);
          if ($urandom_range(0, 9) != 0)
            id += $urandom_range(1, 3);
        end
        off += len;
        send_row(p, win_base[p] + v + 1, off);
      end
    end
  endtask

  task automatic send_noise();
    case ($urandom_range(0, 4))
      0: send_load(OP_EDGE + 3'($urandom_range(1, 3)), 14'($urandom()), $urandom());
      1: send_load($urandom_range(0, 1) ? OP_ROW_TWO : OP_ROW_ONE,
                   14'($urandom_range(VERTS + 1, 16383)), $urandom());
      2: send_load($urandom_range(0, 1) ? OP_NB_TWO : OP_NB_ONE,
                   14'($urandom()), $urandom());
      3: send_edge(board.part_first[0] + $urandom_range(0, 2 * VERTS),
                   board.part_first[1] + $urandom_range(0, 2 * VERTS));
      default: send_edge($urandom(), $urandom());
    endcase
  endtask

  task automatic run_random(input int target);
    int unsigned start;
    int a, b;
    start = words_sent;
    while (words_sent - start < target) begin
      build_graph();
      repeat ($urandom_range(6, 14)) begin
        if ($urandom_range(0, 6) == 0) begin
          send_noise();
        end else begin
          a = win_base[0] + $urandom_range(0, win_count[0] - 1);
          b = win_base[1] + $urandom_range(0, win_count[1] - 1);
          send_edge(board.part_first[0] + 32'(a), board.part_first[1] + 32'(b));
        end
      end
    end
  endtask

  initial begin
    logic [31:0] f1, f2;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_word   = '0;
    cfg_wr_en = 1'b0;
    cfg_index = CFG_ONE_FIRST;
    cfg_data  = '0;
    board     = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();
    run_random(120);

    // stretch with no idling on either side
    in_gap_pct  = 0;
    out_gap_pct = 0;
    run_random(50);
    in_gap_pct  = 38;
    out_gap_pct = 38;

    // full id space: large local indices are flagged
    drain();
    configure(32'd0, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
    run_random(70);

    drain();
    configure(32'hFFFF_FC00, 32'hFFFF_FFFF, 32'h7FFF_FE00, 32'h8000_01FF);
    run_random(70);

    // first above last: every edge flagged
    drain();
    configure(32'd100, 32'd50, 32'd7, 32'd7);
    run_random(25);

    repeat (3) begin
      drain();
      f1 = $urandom();
      f2 = $urandom();
      configure(f1, range_top(f1), f2, range_top(f2));
      run_random(30);
    end

    drain();
    if (board.mismatches == 0 && board.due_words.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
